FILE: hw/rtl/piecewise_bezier_evaluator_macros.svh
// Assertion macros shared by the piecewise Bezier evaluator RTL.
// No dependencies; the checks compile away when SYNTHESIS is defined.
`ifndef PIECEWISE_BEZIER_EVALUATOR_MACROS_SVH
`define PIECEWISE_BEZIER_EVALUATOR_MACROS_SVH
`ifndef SYNTHESIS
`define PBE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");
`define PBE_ASSERT_LAT(lbl, clk, rstn, ante, lat, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> ##lat (cons)) \
    else $error("assertion failed");
`else
`define PBE_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define PBE_ASSERT_LAT(lbl, clk, rstn, ante, lat, cons)
`endif
`endif

FILE: hw/rtl/pbe_pkg.sv
// Shared types and codes for the piecewise Bezier evaluator.
// No dependencies.
package pbe_pkg;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_GRADE   = 2'd0,
    REG_COORDS  = 2'd1,
    REG_SEGMENTS = 2'd2
  } reg_idx_t;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  localparam logic [16:0] T_ONE = 17'h10000;

  // control travelling with each evaluation through the pipeline
  typedef struct packed {
    logic       valid;
    logic [3:0] grade;
    logic       is3d;
    logic [7:0] seg;
  } ctrl_t;

endpackage

FILE: hw/rtl/pbe_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pbe_ram #(
  parameter int W = 32,
  parameter int D = 16
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
  input  logic [W-1:0]                        wdata,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
  output logic [W-1:0]                        rdata
);
  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

FILE: hw/rtl/pbe_level.sv
// One de Casteljau level: a row of registered lerp lanes per coordinate.
// Depends on pbe_pkg.
module pbe_level #(
  parameter int CW    = 32,
  parameter int NP    = 8,
  parameter int LEVEL = 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pbe_pkg::ctrl_t        ctrl_i,
  input  logic [16:0]           u_i,
  input  logic signed [CW-1:0]  pts_i [3][NP],
  output pbe_pkg::ctrl_t        ctrl_o,
  output logic [16:0]           u_o,
  output logic signed [CW-1:0]  pts_o [3][NP]
);
  import pbe_pkg::*;

  ctrl_t                ctrl_r;
  logic [16:0]          u_r;
  logic signed [CW-1:0] pts_r   [3][NP];
  logic signed [CW-1:0] pts_nxt [3][NP];
  logic                 active;

  // this level only works while it lies within the configured degree
  assign active = (ctrl_i.grade >= 4'(LEVEL));

  // lerp lanes: a + ((b - a) * u) >>> 16
  for (genvar c = 0; c < 3; c++) begin : g_coord
    for (genvar j = 0; j < NP; j++) begin : g_lane
      if (j < NP - LEVEL) begin : g_lerp
        logic signed [CW:0]    diff;
        logic signed [CW+18:0] prod;
        assign diff = $signed({pts_i[c][j+1][CW-1], pts_i[c][j+1]})
                    - $signed({pts_i[c][j][CW-1], pts_i[c][j]});
        assign prod = diff * $signed({1'b0, u_i});
        assign pts_nxt[c][j] = active ? (pts_i[c][j] + prod[CW+15:16]) : pts_i[c][j];
      end else begin : g_hold
        assign pts_nxt[c][j] = pts_i[c][j];
      end
    end
  end

  // advance payload
  always_ff @(posedge clk) begin
    pts_r <= pts_nxt;
    u_r   <= u_i;
    ctrl_r.grade <= ctrl_i.grade;
    ctrl_r.is3d  <= ctrl_i.is3d;
    ctrl_r.seg   <= ctrl_i.seg;
  end

  // advance valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r.valid <= 1'b0;
    end else begin
      ctrl_r.valid <= ctrl_i.valid;
    end
  end

  assign ctrl_o = ctrl_r;
  assign u_o    = u_r;
  assign pts_o  = pts_r;
endmodule

FILE: hw/rtl/piecewise_bezier_evaluator.sv
// Top level of the piecewise Bezier evaluator: point store, segment select,
// de Casteljau pipeline and result register. Depends on pbe_pkg, pbe_ram,
// pbe_level and piecewise_bezier_evaluator_macros.svh.
//
// The block accepts one transaction every clock cycle (busy is always low).
// A write stores one control point and gives no result. An evaluation
// gives exactly one result, strobed by out_valid for one cycle, after it
// passes the capture register, segment selection with the point-store read,
// one register per de Casteljau level (MAX_GRADE levels, a level beyond the
// configured degree passes its points through) and the result register.
// The receiver cannot stall the block; results come out in acceptance order.
// A point written is visible to any later evaluation.
`include "piecewise_bezier_evaluator_macros.svh"
module piecewise_bezier_evaluator #(
  parameter int SEGMENTS    = 16,
  parameter int MAX_GRADE   = 7,
  parameter int COORD_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_operation,
  input  logic [3:0]         in_segment_index,
  input  logic [2:0]         in_point_index,
  input  logic signed [31:0] in_x_in,
  input  logic signed [31:0] in_y_in,
  input  logic signed [31:0] in_z_in,
  input  logic [16:0]        in_param_t,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [4:0]         cfg_wdata,
  output logic               out_valid,
  output logic signed [31:0] out_x_out,
  output logic signed [31:0] out_y_out,
  output logic signed [31:0] out_z_out,
  output logic [3:0]         out_segment_used
);
  import pbe_pkg::*;

  localparam int CW  = COORD_WIDTH;
  localparam int NP  = MAX_GRADE + 1;
  localparam int SA  = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
  localparam int NW  = $clog2(SEGMENTS + 1);
  localparam int LAT = MAX_GRADE + 3;

  // configuration registers
  logic [2:0] grade_cfg_r;
  logic [1:0] coords_cfg_r;
  logic [4:0] segs_cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grade_cfg_r  <= 3'd3;
      coords_cfg_r <= 2'd2;
      segs_cfg_r   <= 5'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GRADE:    grade_cfg_r  <= cfg_wdata[2:0];
        REG_COORDS:   coords_cfg_r <= cfg_wdata[1:0];
        REG_SEGMENTS: segs_cfg_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // effective degree and segment count
  logic [3:0]    grade_eff;
  logic [NW-1:0] n_eff;
  always_comb begin
    grade_eff = (grade_cfg_r == 3'd0) ? 4'd1 : 4'(grade_cfg_r);
    if (32'(grade_eff) > MAX_GRADE) begin
      grade_eff = 4'(MAX_GRADE);
    end
    if (segs_cfg_r == 5'd0) begin
      n_eff = NW'(1);
    end else if (32'(segs_cfg_r) > SEGMENTS) begin
      n_eff = NW'(SEGMENTS);
    end else begin
      n_eff = NW'(segs_cfg_r);
    end
  end

  // point store: one bank per point position, addressed by segment
  logic              wr_ok;
  logic [SA-1:0]     wr_addr;
  logic [3*CW-1:0]   wr_data;
  logic [3*CW-1:0]   rd_data [NP];
  logic [SA-1:0]     rd_addr;

  assign wr_ok   = accept && (in_operation == OP_WRITE)
                && (32'(in_segment_index) < SEGMENTS)
                && (32'(in_point_index) <= MAX_GRADE);
  assign wr_addr = SA'(in_segment_index);
  assign wr_data = {CW'(in_z_in), CW'(in_y_in), CW'(in_x_in)};

  for (genvar j = 0; j < NP; j++) begin : g_bank
    pbe_ram #(.W(3*CW), .D(SEGMENTS)) u_bank (
      .clk   (clk),
      .we    (wr_ok && (32'(in_point_index) == j)),
      .waddr (wr_addr),
      .wdata (wr_data),
      .raddr (rd_addr),
      .rdata (rd_data[j])
    );
  end

  // stage 1: capture the evaluation and its saturated parameter
  logic        v1_r;
  logic [16:0] t1_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= accept && (in_operation == OP_EVAL);
    end
  end
  always_ff @(posedge clk) begin
    t1_r <= (in_param_t > T_ONE) ? T_ONE : in_param_t;
  end

  // select segment and local parameter
  logic [16+NW:0] prod_tn;
  logic [NW:0]    seg_raw;
  logic           seg_clamp;
  logic [SA-1:0]  seg_sel;
  logic [16:0]    u_sel;
  always_comb begin
    prod_tn   = t1_r * n_eff;
    seg_raw   = prod_tn[16+NW:16];
    seg_clamp = (seg_raw >= (NW+1)'(n_eff));
    seg_sel   = seg_clamp ? SA'(n_eff - NW'(1)) : SA'(seg_raw);
    u_sel     = seg_clamp ? T_ONE : {1'b0, prod_tn[15:0]};
  end
  assign rd_addr = seg_sel;

  // stage 2: points arrive from the store
  ctrl_t       ctrl2_r;
  logic [16:0] u2_r;
  always_ff @(posedge clk) begin
    u2_r          <= u_sel;
    ctrl2_r.grade <= grade_eff;
    ctrl2_r.is3d  <= (coords_cfg_r == 2'd3);
    ctrl2_r.seg   <= 8'(seg_sel);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl2_r.valid <= 1'b0;
    end else begin
      ctrl2_r.valid <= v1_r;
    end
  end

  // de Casteljau levels
  logic signed [CW-1:0] chain [MAX_GRADE+1][3][NP];
  ctrl_t                ctrl_c [MAX_GRADE+1];
  logic [16:0]          u_c    [MAX_GRADE+1];

  for (genvar c = 0; c < 3; c++) begin : g_load
    for (genvar j = 0; j < NP; j++) begin : g_pt
      assign chain[0][c][j] = rd_data[j][c*CW +: CW];
    end
  end
  assign ctrl_c[0] = ctrl2_r;
  assign u_c[0]    = u2_r;

  for (genvar i = 1; i <= MAX_GRADE; i++) begin : g_lvl
    pbe_level #(.CW(CW), .NP(NP), .LEVEL(i)) u_level (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctrl_i (ctrl_c[i-1]),
      .u_i    (u_c[i-1]),
      .pts_i  (chain[i-1]),
      .ctrl_o (ctrl_c[i]),
      .u_o    (u_c[i]),
      .pts_o  (chain[i])
    );
  end

  // result register
  ctrl_t last;
  logic  out_valid_r;
  logic signed [31:0] x_r, y_r, z_r;
  logic [3:0] seg_r;
  assign last = ctrl_c[MAX_GRADE];

  always_ff @(posedge clk) begin
    x_r   <= 32'(chain[MAX_GRADE][0][0]);
    y_r   <= 32'(chain[MAX_GRADE][1][0]);
    z_r   <= last.is3d ? 32'(chain[MAX_GRADE][2][0]) : 32'sd0;
    seg_r <= last.seg[3:0];
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= last.valid;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_x_out        = x_r;
  assign out_y_out        = y_r;
  assign out_z_out        = z_r;
  assign out_segment_used = seg_r;

  // checks
  `PBE_ASSERT_LAT(a_eval_gives_result, clk, rst_n, accept && in_operation == OP_EVAL, LAT, out_valid)
  `PBE_ASSERT_LAT(a_write_gives_none, clk, rst_n, accept && in_operation == OP_WRITE, LAT, !out_valid)
  `PBE_ASSERT_IMP(a_u_in_range, clk, rst_n, ctrl2_r.valid, u2_r <= T_ONE)
  `PBE_ASSERT_IMP(a_flat_z_zero, clk, rst_n, out_valid && coords_cfg_r != 2'd3, out_z_out == 32'sd0)
endmodule

FILE: tb/piecewise_bezier_evaluator_tb.sv
// Self-checking testbench for the piecewise Bezier evaluator: writes control
// points, evaluates curves and compares against an in-bench de Casteljau predictor.
// Depends on pbe_pkg and the piecewise_bezier_evaluator RTL.
module piecewise_bezier_evaluator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pbe_pkg::*;

  localparam int SEGS = 16;
  localparam int PTS = 8;
  localparam int LATENCY = 10;
  localparam int WATCHDOG = 5000;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [3:0]         seg;
  } curve_point_t;

  // Curve predictor and queue of expected curve points
  class curve_scoreboard;
    logic signed [31:0] px [SEGS*PTS];
    logic signed [31:0] py [SEGS*PTS];
    logic signed [31:0] pz [SEGS*PTS];
    int grade = 3;
    int coords = 2;
    int nseg = 1;
    curve_point_t pending [$];
    int mismatches = 0;

    function void set_reg(reg_idx_t idx, logic [4:0] val);
      case (idx)
        REG_GRADE:    grade = val[2:0];
        REG_COORDS:   coords = val[1:0];
        REG_SEGMENTS: nseg = val;
        default: ;
      endcase
    endfunction

    function longint lerp(longint a, longint b, longint u);
      longint d;
      d = b - a;
      if (u >= 65536) return b;
      return a + ((d * u) >>> 16);
    endfunction

    function longint casteljau(ref logic signed [31:0] st [SEGS*PTS], int base,
                               int g, longint u);
      longint buf_q [PTS];
      for (int i = 0; i <= g; i++) buf_q[i] = st[base+i];
      for (int i = 1; i <= g; i++)
        for (int j = 0; j + i <= g; j++) buf_q[j] = lerp(buf_q[j], buf_q[j+1], u);
      return buf_q[0];
    endfunction

    // Note an accepted transaction: store a point or predict an evaluation
    function void note_input(logic op, logic [3:0] si, logic [2:0] pi,
                             logic signed [31:0] x, logic signed [31:0] y,
                             logic signed [31:0] z, logic [16:0] t);
      int g, n, sg, base;
      longint p, tt, u;
      curve_point_t r;
      if (op == OP_WRITE) begin
        px[si*PTS+pi] = x;
        py[si*PTS+pi] = y;
        pz[si*PTS+pi] = z;
        return;
      end
      g = (grade < 1) ? 1 : grade;
      n = (nseg < 1) ? 1 : (nseg > SEGS ? SEGS : nseg);
      tt = (t > 65536) ? 65536 : t;
      p = tt * n;
      sg = p >> 16;
      if (sg >= n) sg = n - 1;
      u = p - (longint'(sg) << 16);
      base = sg * PTS;
      r.x = casteljau(px, base, g, u);
      r.y = casteljau(py, base, g, u);
      r.z = (coords == 3) ? casteljau(pz, base, g, u) : 0;
      r.seg = sg;
      pending.push_back(r);
    endfunction

    // Compare one strobed result with the oldest expectation
    function void check_result(curve_point_t act);
      curve_point_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result x=%0d", act.x);
        return;
      end
      e = pending.pop_front();
      if (act.x !== e.x || act.y !== e.y || act.z !== e.z || act.seg !== e.seg) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp x=%0d y=%0d z=%0d seg=%0d, got x=%0d y=%0d z=%0d seg=%0d",
                   e.x, e.y, e.z, e.seg, act.x, act.y, act.z, act.seg);
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0, start = 0, busy;
  logic in_operation = 0;
  logic [3:0] in_segment_index = 0;
  logic [2:0] in_point_index = 0;
  logic signed [31:0] in_x_in = 0, in_y_in = 0, in_z_in = 0;
  logic [16:0] in_param_t = 0;
  logic cfg_we = 0;
  logic [1:0] cfg_index = 0;
  logic [4:0] cfg_wdata = 0;
  logic out_valid;
  logic signed [31:0] out_x_out, out_y_out, out_z_out;
  logic [3:0] out_segment_used;

  curve_scoreboard sb = new();
  bit written [SEGS*PTS];
  bit no_idle = 0;
  int idle_cycles = 0;

  piecewise_bezier_evaluator dut (.*);

  initial forever #5 clk = ~clk;

  // Check results and count cycles with no transaction and no result
  always @(posedge clk) begin
    curve_point_t r;
    if (rst_n) begin
      if (out_valid) begin
        r.x = out_x_out; r.y = out_y_out; r.z = out_z_out; r.seg = out_segment_used;
        sb.check_result(r);
      end
      if ((start && !busy) || out_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Drop start for a random burst of idle cycles
  task automatic idle_burst();
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      start <= 0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  // Send one transaction and hold it until accepted
  task automatic send(logic op, logic [3:0] si, logic [2:0] pi, logic signed [31:0] x,
                      logic signed [31:0] y, logic signed [31:0] z, logic [16:0] t);
    start <= 1;
    in_operation <= op; in_segment_index <= si; in_point_index <= pi;
    in_x_in <= x; in_y_in <= y; in_z_in <= z; in_param_t <= t;
    do @(posedge clk); while (busy);
    sb.note_input(op, si, pi, x, y, z, t);
    if (op == OP_WRITE) written[si*PTS+pi] = 1;
  endtask

  task automatic write_point(int s, int p, logic signed [31:0] x,
                             logic signed [31:0] y, logic signed [31:0] z);
    send(OP_WRITE, s, p, x, y, z, $urandom);
    idle_burst();
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 4))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed($urandom_range(0, 2000000)) - 1000000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [16:0] rand_t();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return T_ONE;
      2: return $urandom_range(T_ONE + 1, 17'h1ffff);
      default: return $urandom_range(0, T_ONE);
    endcase
  endfunction

  // Callers evaluate only when every point of every active segment is written; this task does not check it
  task automatic evaluate(logic [16:0] t);
    send(OP_EVAL, $urandom, $urandom, $urandom, $urandom, $urandom, t);
    idle_burst();
  endtask

  // Hold off new transactions until every expected result has come
  task automatic drain();
    start <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic set_cfg(reg_idx_t idx, logic [4:0] val);
    cfg_we <= 1; cfg_index <= idx; cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  task automatic fill_all();
    for (int s = 0; s < SEGS; s++)
      for (int p = 0; p < PTS; p++) write_point(s, p, rand_coord(), rand_coord(),
                                                rand_coord());
  endtask

  initial begin
    int g, c, n;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: fill store, extremes of t at reset settings
    fill_all();
    evaluate(0);
    evaluate(T_ONE);
    evaluate(17'h1ffff);
    evaluate(17'h8000);
    write_point(0, 0, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
    write_point(0, 1, 32'sh80000000, 32'sh7fffffff, 32'sh80000000);
    drain();
    set_cfg(REG_GRADE, 1);
    set_cfg(REG_COORDS, 3);
    set_cfg(REG_SEGMENTS, 16);
    evaluate(17'hffff);
    evaluate(T_ONE);
    evaluate(0);
    evaluate(17'h1000);
    drain();
    set_cfg(REG_GRADE, 7);
    set_cfg(REG_SEGMENTS, 0);
    evaluate(17'h4000);
    evaluate(T_ONE);
    drain();
    set_cfg(REG_SEGMENTS, 31);
    set_cfg(REG_COORDS, 0);
    set_cfg(REG_GRADE, 0);
    evaluate(T_ONE);
    evaluate(17'h7777);

    // Random phases: new settings, point rewrites and evaluations
    for (int ph = 0; ph < 12; ph++) begin
      drain();
      g = $urandom_range(0, 7);
      c = $urandom_range(0, 3);
      n = (ph % 4 == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16);
      if (ph == 0) begin g = 7; n = 16; c = 3; end
      if (ph == 1) begin g = 1; n = 1; c = 2; end
      set_cfg(REG_GRADE, g);
      set_cfg(REG_COORDS, c);
      set_cfg(REG_SEGMENTS, n);
      no_idle = (ph >= 10);
      for (int k = 0; k < 90; k++) begin
        if ($urandom_range(0, 2) == 0)
          write_point($urandom, $urandom, rand_coord(), rand_coord(), rand_coord());
        else
          evaluate(rand_t());
        if (k == 50 && ph == 5) drain();
      end
    end

    drain();
    if (sb.mismatches == 0 && sb.pending.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
